>>> hdl/lcdnw_pkg.sv
// Package: shared types, codes and constants of the character-LCD nibble write sequencer.
`default_nettype none

package lcdnw_pkg;

  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned STEP_W     = 4;

  // Input command codes.
  typedef enum logic [2:0] {
    MODE_INSTR  = 3'd0,
    MODE_DATA   = 3'd1,
    MODE_INIT   = 3'd2,
    MODE_GOTO   = 3'd3,
    MODE_ONOFF  = 3'd4,
    MODE_SHIFT  = 3'd5
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_WAIT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WAIT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_WAIT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP    = 8'd3;

  localparam logic [WAIT_W-1:0] RST_INSTR_WAIT = 16'd2000;
  localparam logic [WAIT_W-1:0] RST_DATA_WAIT  = 16'd40;
  localparam logic [WAIT_W-1:0] RST_POWER_WAIT = 16'd50000;
  localparam logic [WAIT_W-1:0] RST_INIT_STEP  = 16'd10000;

  // Instruction bytes of the controller.
  localparam logic [7:0] LCD_FUNC_SET_4BIT = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_OFF   = 8'h08;
  localparam logic [7:0] LCD_CLEAR         = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE    = 8'h06;
  localparam logic [7:0] LCD_DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] LCD_SET_DDRAM     = 8'h80;
  localparam logic [7:0] LCD_LINE2_OFFSET  = 8'h40;
  localparam logic [7:0] LCD_SHIFT_BASE    = 8'h10;

  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_4BIT    = 4'h2;

  // Init sequence: four wake nibbles, then five set-up bytes of two pulses each.
  localparam logic [STEP_W-1:0] INIT_WAKE_STEPS = 4'd4;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd13;

  typedef enum logic [0:0] {
    KIND_BYTE = 1'b0,
    KIND_INIT = 1'b1
  } kind_t;

  // One queued command.
  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic              head_valid;
    logic              push_ready;
  } q_status_t;

  typedef struct packed {
    logic [WAIT_W-1:0] instr_wait;
    logic [WAIT_W-1:0] data_wait;
    logic [WAIT_W-1:0] power_wait;
    logic [WAIT_W-1:0] init_step;
  } cfg_t;

  typedef struct packed {
    logic              rs;
    logic [3:0]        nib;
    logic [WAIT_W-1:0] pre_wait;
    logic [WAIT_W-1:0] post_wait;
    logic              last;
  } pulse_t;

  function automatic logic [7:0] setup_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = LCD_FUNC_SET_4BIT;
      3'd1:    b = LCD_DISPLAY_OFF;
      3'd2:    b = LCD_CLEAR;
      3'd3:    b = LCD_ENTRY_MODE;
      default: b = LCD_DISPLAY_ON;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/char_lcd_nibble_write_sequencer_top.sv
// Top level of the character-LCD 4-bit write sequencer: config registers and block wiring.
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         req_valid/req_ready     mode, value, column, line, cursor_on,
//                                              blink_on, shift_display, shift_right
// pulse     out        pulse_valid/pulse_ready reg_select, nibble, pre_wait_us,
//                                              post_wait_us, last_pulse
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// The pulse sequencer issues one pulse per cycle through its output register while the
// pulse channel is not stalled; an instruction or data request makes 2 pulses, an init
// request 14. A request is decoded in the cycle it is accepted and enters a two-entry
// queue, and its first pulse then goes through the output register. Modes 6 and 7 are
// accepted and dropped. Reset empties the queue, clears the output valid flag and loads
// the default waits. A stalled pulse channel fills the queue, after which req_ready falls;
// the config port is always ready.
module char_lcd_nibble_write_sequencer_top
  import lcdnw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [2:0]           mode,
  input  wire logic [7:0]           value,
  input  wire logic [7:0]           column,
  input  wire logic                 line,
  input  wire logic                 cursor_on,
  input  wire logic                 blink_on,
  input  wire logic                 shift_display,
  input  wire logic                 shift_right,
  output logic                      pulse_valid,
  input  wire logic                 pulse_ready,
  output logic                      reg_select,
  output logic [3:0]                nibble,
  output logic [WAIT_W-1:0]         pre_wait_us,
  output logic [WAIT_W-1:0]         post_wait_us,
  output logic                      last_pulse,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WAIT_W-1:0]    cfg_data
);

  cfg_t      cfg;
  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head;
  pulse_t    pulse;
  logic      push_valid;
  logic      pop;

  // Configuration writes land directly; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.instr_wait <= RST_INSTR_WAIT;
      cfg.data_wait  <= RST_DATA_WAIT;
      cfg.power_wait <= RST_POWER_WAIT;
      cfg.init_step  <= RST_INIT_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INSTR_WAIT: cfg.instr_wait <= cfg_data;
        CFG_DATA_WAIT:  cfg.data_wait  <= cfg_data;
        CFG_POWER_WAIT: cfg.power_wait <= cfg_data;
        CFG_INIT_STEP:  cfg.init_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The request channel is ready whenever the queue has room, regardless of
  // whether the decoded mode produces any pulses.
  assign req_ready = q_status.push_ready;

  lcdnw_front u_front (
    .req_valid     (req_valid),
    .mode          (mode),
    .value         (value),
    .column        (column),
    .line          (line),
    .cursor_on     (cursor_on),
    .blink_on      (blink_on),
    .shift_display (shift_display),
    .shift_right   (shift_right),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd)
  );

  lcdnw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .status     (q_status),
    .head       (head)
  );

  lcdnw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_status.head_valid),
    .head        (head),
    .cfg         (cfg),
    .pop         (pop),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse)
  );

  assign reg_select   = pulse.rs;
  assign nibble       = pulse.nib;
  assign pre_wait_us  = pulse.pre_wait;
  assign post_wait_us = pulse.post_wait;
  assign last_pulse   = pulse.last;

  // Only init wake nibbles carry a pre-pulse wait, and those go to the instruction register.
  a_pre_wait_instr: assert property (@(posedge clk) disable iff (rst)
    (pulse_valid && pre_wait_us != '0) |-> !reg_select)
    else $error("pre-pulse wait on a data register pulse");

  // A settle wait only follows the final pulse of a byte, never the high nibble.
  a_post_wait_last: assert property (@(posedge clk) disable iff (rst)
    (pulse_valid && !last_pulse && post_wait_us != '0) |->
      (!reg_select && pre_wait_us == '0))
    else $error("settle wait on a data high nibble");

  // A decodable request must leave a command in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && mode <= MODE_SHIFT) |=> q_status.head_valid)
    else $error("accepted command missing from queue");

  // With nothing queued the sequencer cannot present a new pulse.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!q_status.head_valid && (!pulse_valid || pulse_ready)) |=> !pulse_valid)
    else $error("pulse issued from an empty queue");

endmodule

`default_nettype wire

>>> hdl/lcdnw_front.sv
// Front end: decodes an incoming request into a queued command byte or init sequence.
`default_nettype none

module lcdnw_front
  import lcdnw_pkg::*;
(
  input  wire logic       req_valid,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] value,
  input  wire logic [7:0] column,
  input  wire logic       line,
  input  wire logic       cursor_on,
  input  wire logic       blink_on,
  input  wire logic       shift_display,
  input  wire logic       shift_right,
  output logic            push_valid,
  output cmd_t            push_cmd
);

  logic [7:0] goto_byte;
  logic       known;

  always_comb begin
    goto_byte = LCD_SET_DDRAM | (line ? LCD_LINE2_OFFSET : 8'h00);
    if (column < 8'd16) begin
      goto_byte = goto_byte | column;
    end
  end

  always_comb begin
    known         = 1'b1;
    push_cmd.kind = KIND_BYTE;
    push_cmd.rs   = 1'b0;
    push_cmd.data = value;
    unique case (mode)
      MODE_INSTR: ;
      MODE_DATA:  push_cmd.rs = 1'b1;
      MODE_INIT:  push_cmd.kind = KIND_INIT;
      MODE_GOTO:  push_cmd.data = goto_byte;
      MODE_ONOFF: push_cmd.data = LCD_DISPLAY_ON | {6'd0, cursor_on, blink_on};
      MODE_SHIFT: push_cmd.data = LCD_SHIFT_BASE | {4'd0, shift_display, shift_right, 2'd0};
      default:    known = 1'b0;  // Unused codes produce nothing.
    endcase
    push_valid = req_valid && known;
  end

endmodule

`default_nettype wire

>>> hdl/lcdnw_queue.sv
// Two-entry command queue between the decoder and the pulse sequencer.
`default_nettype none

module lcdnw_queue
  import lcdnw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output q_status_t status,
  output cmd_t      head
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign status.push_ready = (count != 2'd2);
  assign status.head_valid = (count != 2'd0);
  assign push              = push_valid && status.push_ready;
  assign head              = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcdnw_back.sv
// Back end: steps through head command pulses, one per cycle unless stalled.
`default_nettype none

module lcdnw_back
  import lcdnw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire cmd_t head,
  input  wire cfg_t cfg,
  output logic      pop,
  output logic      pulse_valid,
  input  wire logic pulse_ready,
  output pulse_t    pulse
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] setup_step;
  logic [7:0]        cur_byte;
  logic              adv;
  logic              fire;
  pulse_t            p;

  always_comb begin
    setup_step = step - INIT_WAKE_STEPS;
    cur_byte   = setup_byte(setup_step[3:1]);
    p.rs        = 1'b0;
    p.nib       = '0;
    p.pre_wait  = '0;
    p.post_wait = '0;
    p.last      = 1'b0;
    unique case (head.kind)
      KIND_BYTE: begin
        p.rs   = head.rs;
        p.nib  = step[0] ? head.data[3:0] : head.data[7:4];
        p.last = step[0];
        if (step[0]) begin
          p.post_wait = head.rs ? cfg.data_wait : cfg.instr_wait;
        end
      end
      KIND_INIT: begin
        if (step < INIT_WAKE_STEPS) begin
          p.nib      = (step == INIT_WAKE_STEPS - 4'd1) ? NIB_4BIT : NIB_WAKE;
          p.pre_wait = (step == '0) ? cfg.power_wait : cfg.init_step;
        end else begin
          p.nib       = setup_step[0] ? cur_byte[3:0] : cur_byte[7:4];
          p.post_wait = setup_step[0] ? cfg.instr_wait : '0;
        end
        p.last = (step == INIT_LAST_STEP);
      end
      default: ;
    endcase
    adv  = !pulse_valid || pulse_ready;
    fire = adv && head_valid;
    pop  = fire && p.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
      step        <= '0;
    end else begin
      if (adv) begin
        pulse_valid <= head_valid;
      end
      if (fire) begin
        step <= p.last ? '0 : step + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse <= p;
    end
  end

endmodule

`default_nettype wire

>>> test/char_lcd_nibble_write_sequencer_top_tb.sv
// Self-checking testbench for the character-LCD 4-bit write sequencer top level.
module char_lcd_nibble_write_sequencer_top_tb
  import lcdnw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes 6 and 7 carry no command; the block takes them and drops them.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  // Set-up bytes of the power-on sequence, in send order from bit slice 0 up.
  localparam logic [4:0][7:0] SETUP_SEQ = {LCD_DISPLAY_ON, LCD_ENTRY_MODE, LCD_CLEAR,
                                           LCD_DISPLAY_OFF, LCD_FUNC_SET_4BIT};

  // A dropped request leaves nothing to wait for, and an init request is at most
  // 14 pulses long, so this many quiet cycles after the last pulse means idle.
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 26;
  localparam int NUM_DIRECTED   = 21;

  // Receiver behavior on the pulse channel.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_style_t;

  // One command request as it goes onto the request channel.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [7:0] column;
    logic       line;
    logic       cursor_on;
    logic       blink_on;
    logic       shift_display;
    logic       shift_right;
  } lcd_req_t;

  // A directed row; when typed is set, cmd_byte is the instruction or data byte
  // that the row must produce, read straight off the instruction set.
  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    logic [7:0] cmd_byte;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic [2:0]           mode = '0;
  logic [7:0]           value = '0;
  logic [7:0]           column = '0;
  logic                 line = 1'b0;
  logic                 cursor_on = 1'b0;
  logic                 blink_on = 1'b0;
  logic                 shift_display = 1'b0;
  logic                 shift_right = 1'b0;
  logic                 pulse_valid;
  logic                 pulse_ready = 1'b0;
  logic                 reg_select;
  logic [3:0]           nibble;
  logic [WAIT_W-1:0]    pre_wait_us;
  logic [WAIT_W-1:0]    post_wait_us;
  logic                 last_pulse;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WAIT_W-1:0]    cfg_data = '0;

  // Local copy of the four wait registers, updated on every accepted write.
  cfg_t waits = '{RST_INSTR_WAIT, RST_DATA_WAIT, RST_POWER_WAIT, RST_INIT_STEP};

  // Enable pulses still owed by the block, oldest first.
  pulse_t due_pulses [$];

  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  rx_style_t rx_style = RX_ALWAYS;
  int        stall_tick = 0;

  dir_row_t directed [0:NUM_DIRECTED-1] = '{
    '{'{MODE_INSTR, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h00},
    '{'{MODE_INSTR, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 8'hFF},
    '{'{MODE_DATA,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h00},
    '{'{MODE_DATA,  8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'hFF},
    '{'{MODE_DATA,  8'hA5, 8'h3C, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, 8'h00},
    '{'{MODE_INIT,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
    '{'{MODE_GOTO,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h80},
    '{'{MODE_GOTO,  8'h00, 8'h0F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'hCF},
    '{'{MODE_GOTO,  8'hFF, 8'h10, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h80},
    '{'{MODE_GOTO,  8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, 8'hC0},
    '{'{MODE_GOTO,  8'h5A, 8'h07, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
    '{'{MODE_ONOFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, 8'h0C},
    '{'{MODE_ONOFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, 8'h0F},
    '{'{MODE_ONOFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
    '{'{MODE_SHIFT, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, 8'h10},
    '{'{MODE_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, 8'h1C},
    '{'{MODE_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, 8'h14},
    '{'{MODE_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, 8'h00},
    '{'{MODE_SPARE_A, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, 8'h00},
    '{'{MODE_SPARE_B, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
    '{'{MODE_INSTR, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00}
  };

  char_lcd_nibble_write_sequencer_top uut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .mode          (mode),
    .value         (value),
    .column        (column),
    .line          (line),
    .cursor_on     (cursor_on),
    .blink_on      (blink_on),
    .shift_display (shift_display),
    .shift_right   (shift_right),
    .pulse_valid   (pulse_valid),
    .pulse_ready   (pulse_ready),
    .reg_select    (reg_select),
    .nibble        (nibble),
    .pre_wait_us   (pre_wait_us),
    .post_wait_us  (post_wait_us),
    .last_pulse    (last_pulse),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per mismatch and keeps the count for the final verdict.
  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // The byte a single-byte command puts on the bus. Goto drops any column past
  // the last visible one (16 or more) to column 0, and line 1 adds the offset
  // of the second display line.
  function automatic logic [7:0] command_byte(input lcd_req_t r);
    logic [7:0] b;
    case (r.mode)
      MODE_INSTR, MODE_DATA: b = r.value;
      MODE_GOTO: begin
        b = LCD_SET_DDRAM | (r.line ? LCD_LINE2_OFFSET : 8'h00);
        if (r.column < 8'd16) b = b | r.column;
      end
      MODE_ONOFF: b = LCD_DISPLAY_ON | {6'b0, r.cursor_on, r.blink_on};
      MODE_SHIFT: b = LCD_SHIFT_BASE | {4'b0, r.shift_display, r.shift_right, 2'b0};
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // A byte is two pulses, high nibble first; only the second one carries the
  // settle wait.
  task automatic owe_byte(input logic rs, input logic [7:0] b,
                          input logic [WAIT_W-1:0] settle, input logic last);
    due_pulses.push_back('{rs, b[7:4], 16'd0, 16'd0, 1'b0});
    due_pulses.push_back('{rs, b[3:0], 16'd0, settle, last});
  endtask

  // Works out every pulse that one accepted request causes. A typed row
  // supplies its byte directly instead of having it computed.
  task automatic sequence_pulses(input lcd_req_t r, input logic typed,
                                 input logic [7:0] typed_byte);
    logic [7:0] b;
    int         i;
    b = typed ? typed_byte : command_byte(r);
    case (r.mode)
      MODE_INSTR, MODE_GOTO, MODE_ONOFF, MODE_SHIFT:
        owe_byte(1'b0, b, waits.instr_wait, 1'b1);
      MODE_DATA:
        owe_byte(1'b1, b, waits.data_wait, 1'b1);
      MODE_INIT: begin
        // Wake-up nibbles go to the instruction register with a wait before
        // each pulse and none after it; the first one waits out power-on.
        due_pulses.push_back('{1'b0, NIB_WAKE, waits.power_wait, 16'd0, 1'b0});
        due_pulses.push_back('{1'b0, NIB_WAKE, waits.init_step, 16'd0, 1'b0});
        due_pulses.push_back('{1'b0, NIB_WAKE, waits.init_step, 16'd0, 1'b0});
        due_pulses.push_back('{1'b0, NIB_4BIT, waits.init_step, 16'd0, 1'b0});
        for (i = 0; i < 5; i++) begin
          owe_byte(1'b0, SETUP_SEQ[i], waits.instr_wait, i == 4);
        end
      end
      default: ;  // Spare mode codes cause no pulse.
    endcase
  endtask

  // Puts one request on the channel, pacing the sender in bursts with random
  // gaps between them when gaps_on is set. Called at a falling edge; returns at a falling edge with
  // valid still high, so a back-to-back request keeps it high.
  task automatic issue_request(input lcd_req_t r, input logic typed,
                               input logic [7:0] typed_byte);
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    req_valid     <= 1'b1;
    mode          <= r.mode;
    value         <= r.value;
    column        <= r.column;
    line          <= r.line;
    cursor_on     <= r.cursor_on;
    blink_on      <= r.blink_on;
    shift_display <= r.shift_display;
    shift_right   <= r.shift_right;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sequence_pulses(r, typed, typed_byte);
    burst_left--;
    @(negedge clk);
  endtask

  // Stops the sender and waits until every owed pulse has come and the block
  // has had time to finish any dropped request. Called at a falling edge.
  task automatic drain_requests();
    req_valid  <= 1'b0;
    burst_left = 0;
    while (due_pulses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; valid stays high on return so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WAIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INSTR_WAIT: waits.instr_wait = data;
      CFG_DATA_WAIT:  waits.data_wait  = data;
      CFG_POWER_WAIT: waits.power_wait = data;
      CFG_INIT_STEP:  waits.init_step  = data;
      default: ;  // Indexes past the last register are ignored.
    endcase
    @(negedge clk);
  endtask

  // Loads all four waits, then writes junk to an index that holds no register.
  task automatic program_waits(input cfg_t w);
    write_reg(CFG_INSTR_WAIT, w.instr_wait);
    write_reg(CFG_DATA_WAIT, w.data_wait);
    write_reg(CFG_POWER_WAIT, w.power_wait);
    write_reg(CFG_INIT_STEP, w.init_step);
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), WAIT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // The receiver changes ready on the falling edge, in one of three styles:
  // never stalling, stalling at random, or on a repeating pattern whose
  // period does not line up with the two-pulse rhythm of a byte.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case (rx_style)
      RX_ALWAYS: pulse_ready <= 1'b1;
      RX_RANDOM: pulse_ready <= ($urandom_range(0, 3) != 0);
      default:   pulse_ready <= ((stall_tick % 23) < 15);
    endcase
  end

  // Each accepted pulse is checked, field by field, against the oldest one owed.
  always @(posedge clk) begin : check_pulses
    pulse_t want;
    if (!rst && pulse_valid && pulse_ready) begin
      if (due_pulses.size() == 0) begin
        flag_mismatch($sformatf("unexpected pulse rs=%0b nibble=%h", reg_select, nibble));
      end else begin
        want = due_pulses.pop_front();
        if (reg_select !== want.rs)
          flag_mismatch($sformatf("reg_select got %b want %b", reg_select, want.rs));
        if (nibble !== want.nib)
          flag_mismatch($sformatf("nibble got %h want %h", nibble, want.nib));
        if (pre_wait_us !== want.pre_wait)
          flag_mismatch($sformatf("pre_wait_us got %0d want %0d", pre_wait_us, want.pre_wait));
        if (post_wait_us !== want.post_wait)
          flag_mismatch($sformatf("post_wait_us got %0d want %0d",
                                  post_wait_us, want.post_wait));
        if (last_pulse !== want.last)
          flag_mismatch($sformatf("last_pulse got %b want %b", last_pulse, want.last));
      end
    end
  end

  // The watchdog counts cycles in which no channel moves anything. The longest
  // correct quiet spell is a sender gap, a receiver stall or the settle pause,
  // all far below the limit.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (pulse_valid && pulse_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    lcd_req_t r;
    cfg_t     phase_waits [0:4];
    int       row;
    int       phase;
    int       sent;
    int       pick;

    // Settings for the random phases: all-zero and all-ones waits, a lopsided
    // mix of extremes, and two random sets.
    phase_waits[0] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    phase_waits[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_waits[2] = cfg_t'({$urandom, $urandom});
    phase_waits[3] = '{16'h0001, 16'hFFFF, 16'h0000, 16'h8000};
    phase_waits[4] = cfg_t'({$urandom, $urandom});

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table at the reset waits, receiver stalling at random.
    rx_style = RX_RANDOM;
    for (row = 0; row < NUM_DIRECTED; row++) begin
      issue_request(directed[row].req, directed[row].typed, directed[row].cmd_byte);
    end

    // Random phases. Between phases the sender holds off until every owed
    // pulse has arrived, then the waits are reprogrammed.
    for (phase = 0; phase < 5; phase++) begin
      drain_requests();
      program_waits(phase_waits[phase]);
      rx_style = rx_style_t'(phase % 3);
      gaps_on  = (phase != 1);
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        pick = $urandom_range(0, 15);
        r = lcd_req_t'({$urandom, $urandom});
        // Mostly real commands; about one in sixteen uses a spare mode code.
        r.mode = (pick < 15) ? 3'(pick % 6) : 3'($urandom_range(6, 7));
        // At least half the goto columns stay on the visible range.
        if ($urandom_range(0, 1) == 0) r.column = 8'($urandom_range(0, 15));
        issue_request(r, 1'b0, 8'h00);
        if (r.mode <= MODE_SHIFT) sent++;
      end
    end

    drain_requests();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
